[design/kest_pkg.sv]
// Shared types and constants of the key event state tracker.
`default_nettype none

package kest_pkg;

    // Event codes carried in tuser
    localparam logic [2:0] OP_PRESS   = 3'd0;
    localparam logic [2:0] OP_RELEASE = 3'd1;
    localparam logic [2:0] OP_MOTION  = 3'd2;
    localparam logic [2:0] OP_WHEEL   = 3'd3;
    localparam logic [2:0] OP_FOCUS   = 3'd4;
    localparam logic [2:0] OP_BEGIN   = 3'd5;
    localparam logic [2:0] OP_QUERY   = 3'd6;

    // Stamp value meaning "never"
    localparam logic [31:0] NEVER_STAMP = 32'hFFFF_FFFF;

    // Saturation bounds
    localparam logic signed [24:0] SUM24_MAX = 25'sd8388607;
    localparam logic signed [24:0] SUM24_MIN = -25'sd8388608;
    localparam logic signed [32:0] SUM32_MAX = 33'sd2147483647;
    localparam logic signed [32:0] SUM32_MIN = -33'sd2147483648;

    localparam logic [15:0] WHEEL_GAIN_RESET = 16'd256;

    // Per-key record held in the key memory
    typedef struct packed {
        logic               held;
        logic [31:0]        press_stamp;
        logic [31:0]        release_stamp;
        logic signed [15:0] press_x;
        logic signed [15:0] press_y;
    } key_entry_t;

    localparam int ENTRY_W = $bits(key_entry_t);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_EXEC
    } state_t;

endpackage

`default_nettype wire

[design/kest_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read.
`default_nettype none

module kest_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire                              aclk,
    input  wire                              wr_en,
    input  wire [$clog2(DEPTH)-1:0]          wr_addr,
    input  wire [WIDTH-1:0]                  wr_data,
    input  wire                              rd_en,
    input  wire [$clog2(DEPTH)-1:0]          rd_addr,
    output logic [WIDTH-1:0]                 rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port, holds when not enabled
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

[design/key_event_state_tracker_unit.sv]
// Top level of the key event state tracker: per-key memory, sums and result register.
//
//  channel   dir  handshake              payload
//  s_        in   s_tvalid / s_tready    s_tdata (event fields), s_tuser (op)
//  m_        out  m_tvalid / m_tready    m_tdata (result fields)
//  cfg_      in   cfg_we                 cfg_wdata (wheel_gain)
//
// An event first reads the key memory, then modifies the entry, writes it back
// and loads the result register. A focus-loss event first walks keys 1 to
// KEY_COUNT-1 through the memory, one read a cycle. Reset clears only a
// written-flag per key; unwritten keys read as released, never stamped. No
// clearing pass. The next event is taken while a result waits; the update
// stalls only when the result register is still full.
`default_nettype none

module key_event_state_tracker_unit
    import kest_pkg::*;
#(
    parameter int KEY_COUNT = 128
) (
    input  wire          aclk,
    input  wire          aresetn,
    // config
    input  wire          cfg_we,
    input  wire [15:0]   cfg_wdata,    // wheel_gain
    // event stream
    input  wire          s_tvalid,
    output logic         s_tready,
    // key[7:0], pos_x[23:8], pos_y[39:24], delta_x[55:40], delta_y[71:56],
    // wheel_steps[79:72], focus_flag[80], frame_number[112:81], zero pad
    input  wire [119:0]  s_tdata,
    input  wire [2:0]    s_tuser,      // op[2:0]
    // result stream
    output logic         m_tvalid,
    input  wire          m_tready,
    // edge_res[0], key_held[1], just_pressed[2], just_released[3], press_x[19:4],
    // press_y[35:20], any_held[36], motion_sum_x[60:37], motion_sum_y[84:61],
    // wheel_sum[116:85], pointer_x[132:117], pointer_y[148:133], zero pad
    output logic [151:0] m_tdata
);

    localparam int KW = $clog2(KEY_COUNT);
    localparam logic [8:0]  KEY_LIMIT = 9'(KEY_COUNT);
    localparam logic [KW:0] WALK_END  = (KW + 1)'(KEY_COUNT);
    localparam logic [KW:0] WALK_FIRST = (KW + 1)'(1);

    // Input field split
    logic [7:0]         in_key;
    logic signed [15:0] in_pos_x, in_pos_y, in_dx, in_dy;
    logic signed [7:0]  in_steps;
    logic               in_focus;
    logic [31:0]        in_frame;

    assign in_key   = s_tdata[7:0];
    assign in_pos_x = s_tdata[23:8];
    assign in_pos_y = s_tdata[39:24];
    assign in_dx    = s_tdata[55:40];
    assign in_dy    = s_tdata[71:56];
    assign in_steps = s_tdata[79:72];
    assign in_focus = s_tdata[80];
    assign in_frame = s_tdata[112:81];

    // Registers
    state_t             state_reg, state_next;
    logic [15:0]        gain_reg;
    logic [2:0]         op_reg;
    logic               kvalid_reg;
    logic [KW-1:0]      kidx_reg;
    logic               kzero_reg;
    logic signed [15:0] pos_x_reg, pos_y_reg, dx_reg, dy_reg;
    logic               focus_reg;
    logic [31:0]        frame_reg;
    logic signed [24:0] prod_reg;

    logic [31:0]        cur_frame_reg, cur_frame_next;
    logic [7:0]         held_cnt_reg, held_cnt_next;
    logic signed [23:0] sum_x_reg, sum_x_next, sum_y_reg, sum_y_next;
    logic signed [31:0] wheel_reg, wheel_next;
    logic signed [15:0] cur_x_reg, cur_x_next, cur_y_reg, cur_y_next;
    logic               has_focus_reg, has_focus_next;

    logic [KW:0]        walk_idx_reg, walk_idx_next;
    logic               wb_pend_reg, wb_pend_next;
    logic [KW-1:0]      wb_idx_reg, wb_idx_next;

    logic [KEY_COUNT-1:0] written_reg;
    logic               ent_valid_reg;

    logic               m_tvalid_reg;
    logic [151:0]       m_tdata_reg, m_tdata_next;

    // RAM ports
    logic               ram_we, ram_re;
    logic [KW-1:0]      ram_waddr, ram_raddr;
    key_entry_t         ram_wdata;
    logic [ENTRY_W-1:0] ram_rdata;

    kest_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (KEY_COUNT)
    ) u_key_ram (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_en   (ram_re),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    // Decoded entry: unwritten keys read as released and never stamped
    key_entry_t rd_ent;
    always_comb begin
        rd_ent = key_entry_t'(ram_rdata);
        if (!ent_valid_reg) begin
            rd_ent.held          = 1'b0;
            rd_ent.press_stamp   = NEVER_STAMP;
            rd_ent.release_stamp = NEVER_STAMP;
            rd_ent.press_x       = '0;
            rd_ent.press_y       = '0;
        end
    end

    logic accept, out_free, commit;
    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign commit   = (state_reg == ST_EXEC) && out_free;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // Event evaluation against the item key's entry
    logic               press_edge, release_edge, held_after, jp, jr;
    logic [31:0]        frame_after, pstamp_after, rstamp_after;
    logic signed [15:0] px_after, py_after;
    logic signed [24:0] sx_wide, sy_wide;
    logic signed [32:0] wh_wide;

    always_comb begin
        press_edge   = (op_reg == OP_PRESS) && kvalid_reg && !rd_ent.held;
        release_edge = (op_reg == OP_RELEASE) && kvalid_reg && rd_ent.held;
        held_after   = (rd_ent.held || press_edge) && !release_edge;
        frame_after  = (op_reg == OP_BEGIN) ? frame_reg : cur_frame_reg;
        pstamp_after = press_edge ? cur_frame_reg : rd_ent.press_stamp;
        rstamp_after = release_edge ? cur_frame_reg : rd_ent.release_stamp;
        px_after     = press_edge ? pos_x_reg : rd_ent.press_x;
        py_after     = press_edge ? pos_y_reg : rd_ent.press_y;
        jp           = kvalid_reg && (pstamp_after == frame_after);
        jr           = kvalid_reg && (rstamp_after == frame_after);
        sx_wide      = 25'(sum_x_reg) + 25'(dx_reg);
        sy_wide      = 25'(sum_y_reg) + 25'(dy_reg);
        wh_wide      = 33'(wheel_reg) + 33'(prod_reg);
    end

    // Scalar state update on commit
    always_comb begin
        cur_frame_next = cur_frame_reg;
        held_cnt_next  = held_cnt_reg;
        sum_x_next     = sum_x_reg;
        sum_y_next     = sum_y_reg;
        wheel_next     = wheel_reg;
        cur_x_next     = cur_x_reg;
        cur_y_next     = cur_y_reg;
        has_focus_next = has_focus_reg;
        case (op_reg)
            OP_PRESS: begin
                if (press_edge && !kzero_reg) begin
                    held_cnt_next = held_cnt_reg + 8'd1;
                end
            end
            OP_RELEASE: begin
                if (release_edge && !kzero_reg && held_cnt_reg != '0) begin
                    held_cnt_next = held_cnt_reg - 8'd1;
                end
            end
            OP_MOTION: begin
                if (sx_wide > SUM24_MAX)      sum_x_next = SUM24_MAX[23:0];
                else if (sx_wide < SUM24_MIN) sum_x_next = SUM24_MIN[23:0];
                else                          sum_x_next = sx_wide[23:0];
                if (sy_wide > SUM24_MAX)      sum_y_next = SUM24_MAX[23:0];
                else if (sy_wide < SUM24_MIN) sum_y_next = SUM24_MIN[23:0];
                else                          sum_y_next = sy_wide[23:0];
                cur_x_next = pos_x_reg;
                cur_y_next = pos_y_reg;
            end
            OP_WHEEL: begin
                if (wh_wide > SUM32_MAX)      wheel_next = SUM32_MAX[31:0];
                else if (wh_wide < SUM32_MIN) wheel_next = SUM32_MIN[31:0];
                else                          wheel_next = wh_wide[31:0];
            end
            OP_FOCUS: begin
                has_focus_next = focus_reg;
                if (!focus_reg) begin
                    held_cnt_next = '0;
                end
            end
            OP_BEGIN: begin
                cur_frame_next = frame_reg;
                sum_x_next     = '0;
                sum_y_next     = '0;
                wheel_next     = '0;
            end
            default: begin
            end
        endcase
    end

    // Result packing
    always_comb begin
        m_tdata_next = {
            3'b000,
            cur_y_next,
            cur_x_next,
            wheel_next,
            sum_y_next,
            sum_x_next,
            (held_cnt_next != '0),
            (jp ? py_after : 16'sd0),
            (jp ? px_after : 16'sd0),
            jr,
            jp,
            kvalid_reg && held_after,
            press_edge || release_edge
        };
    end

    // Sequencer: memory access and next state
    always_comb begin
        state_next    = state_reg;
        walk_idx_next = walk_idx_reg;
        wb_pend_next  = wb_pend_reg;
        wb_idx_next   = wb_idx_reg;
        ram_re        = 1'b0;
        ram_raddr     = kidx_reg;
        ram_we        = 1'b0;
        ram_waddr     = kidx_reg;
        ram_wdata     = '{held: held_after, press_stamp: pstamp_after,
                          release_stamp: rstamp_after, press_x: px_after,
                          press_y: py_after};
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (s_tuser == OP_FOCUS && !in_focus) begin
                        walk_idx_next = WALK_FIRST;
                        wb_pend_next  = 1'b0;
                        state_next    = ST_WALK;
                    end else begin
                        ram_re     = ({1'b0, in_key} < KEY_LIMIT);
                        ram_raddr  = in_key[KW-1:0];
                        state_next = ST_EXEC;
                    end
                end
            end
            ST_WALK: begin
                // release the key read last cycle if it was held
                ram_we    = wb_pend_reg && rd_ent.held;
                ram_waddr = wb_idx_reg;
                ram_wdata = '{held: 1'b0, press_stamp: rd_ent.press_stamp,
                              release_stamp: cur_frame_reg, press_x: rd_ent.press_x,
                              press_y: rd_ent.press_y};
                if (walk_idx_reg < WALK_END) begin
                    ram_re        = 1'b1;
                    ram_raddr     = walk_idx_reg[KW-1:0];
                    wb_pend_next  = 1'b1;
                    wb_idx_next   = walk_idx_reg[KW-1:0];
                    walk_idx_next = walk_idx_reg + WALK_FIRST;
                end else begin
                    wb_pend_next = 1'b0;
                    if (!wb_pend_reg) begin
                        // last write is done: fetch the item key
                        ram_re     = kvalid_reg;
                        ram_raddr  = kidx_reg;
                        state_next = ST_EXEC;
                    end
                end
            end
            ST_EXEC: begin
                if (commit) begin
                    ram_we     = press_edge || release_edge;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            gain_reg      <= WHEEL_GAIN_RESET;
            cur_frame_reg <= '0;
            held_cnt_reg  <= '0;
            sum_x_reg     <= '0;
            sum_y_reg     <= '0;
            wheel_reg     <= '0;
            cur_x_reg     <= '0;
            cur_y_reg     <= '0;
            has_focus_reg <= 1'b0;
            written_reg   <= '0;
            wb_pend_reg   <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            state_reg   <= state_next;
            wb_pend_reg <= wb_pend_next;
            if (cfg_we) begin
                gain_reg <= cfg_wdata;
            end
            if (ram_we) begin
                written_reg[ram_waddr] <= 1'b1;
            end
            if (commit) begin
                cur_frame_reg <= cur_frame_next;
                held_cnt_reg  <= held_cnt_next;
                sum_x_reg     <= sum_x_next;
                sum_y_reg     <= sum_y_next;
                wheel_reg     <= wheel_next;
                cur_x_reg     <= cur_x_next;
                cur_y_reg     <= cur_y_next;
                has_focus_reg <= has_focus_next;
            end
            if (commit) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        walk_idx_reg <= walk_idx_next;
        wb_idx_reg   <= wb_idx_next;
        if (ram_re) begin
            ent_valid_reg <= written_reg[ram_raddr];
        end
        if (accept) begin
            op_reg     <= s_tuser;
            kvalid_reg <= ({1'b0, in_key} < KEY_LIMIT);
            kidx_reg   <= in_key[KW-1:0];
            kzero_reg  <= (in_key == 8'd0);
            pos_x_reg  <= in_pos_x;
            pos_y_reg  <= in_pos_y;
            dx_reg     <= in_dx;
            dy_reg     <= in_dy;
            focus_reg  <= in_focus;
            frame_reg  <= in_frame;
            // steps times gain, both widened to the product width
            prod_reg   <= $signed({{17{in_steps[7]}}, in_steps}) * $signed({9'd0, gain_reg});
        end
        if (commit) begin
            m_tdata_reg <= m_tdata_next;
        end
    end

    // Checks
    a_walk_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
        else $error("key memory read and write hit the same entry");

    a_we_in_work: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |-> (state_reg == ST_WALK || state_reg == ST_EXEC))
        else $error("key memory written outside an event");

    a_walk_drained: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_WALK && state_next == ST_EXEC) |-> !wb_pend_reg)
        else $error("walk left with a release write pending");

    a_focus_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (commit && op_reg == OP_FOCUS && !focus_reg) |=> (held_cnt_reg == '0 && !m_tdata[36]))
        else $error("focus loss left keys counted as held");

    a_commit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |-> !commit)
        else $error("result register overwritten while full");

endmodule

`default_nettype wire
